### hw/rtl/bip_pkg.sv
// ----------------------------------------------------------------------------
// bip_pkg
// shared sizes, register indexes and result type of the interleaver packetizer
// ----------------------------------------------------------------------------
package bip_pkg;

	localparam int MAX_DIM     = 8;
	localparam int DIM_W       = $clog2(MAX_DIM);
	localparam int BANK_SIZE   = MAX_DIM * MAX_DIM;
	localparam int BANK_W      = $clog2(BANK_SIZE);
	localparam int STORE_DEPTH = 2 * BANK_SIZE;
	localparam int ADDR_W      = BANK_W + 1;
	localparam int DATA_W      = 32;
	localparam int PT_W        = 7;
	localparam int GEOM_W      = 4;
	localparam int UPL_W       = 8;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int LIVE_W      = 8;
	localparam int HDR_W       = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPL     = 2'd2;

	localparam logic [GEOM_W-1:0] ROWS_RESET    = 4'd4;
	localparam logic [GEOM_W-1:0] COLUMNS_RESET = 4'd4;
	localparam logic [UPL_W-1:0]  UPL_RESET     = 8'd1;

	typedef struct packed {
		logic             present;
		logic             packet_ready;
		logic             new_timestamp;
		logic [HDR_W-1:0] header_word;
	} result_t;

endpackage

### hw/rtl/block_interleaver_packetizer_top.sv
// ----------------------------------------------------------------------------
// block_interleaver_packetizer_top
// double-buffered block interleaver with packet header generation
//
//  channel   dir  tdata                          tuser                    tlast
//  s_axis    in   [31:0] unit_data               [0] present [7:1] pt     -
//  m_axis    out  [31:0] out_data [63:32] header [0] present [1] new_ts   packet_ready
//  cfg       in   cfg_data[7:0] at cfg_index when cfg_we
//
// one transfer in and one out per cycle unless the output stalls; a result
// goes to the result stage, then the output register. the store is one
// 128-entry memory, written and read once per cycle in opposite banks;
// valid bits sit in flops and reset clears them at once. a stalled output
// keeps two results (stage and output register) before input tready drops.
// ----------------------------------------------------------------------------
module block_interleaver_packetizer_top
	import bip_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // [31:0] unit_data
	input  logic [7:0]           s_axis_tuser,  // [0] unit_present, [7:1] unit_payload_type
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // [31:0] out_data, [63:32] header_word
	output logic [1:0]           m_axis_tuser,  // [0] out_present, [1] new_timestamp
	output logic                 m_axis_tlast,  // packet_ready
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [GEOM_W-1:0] rows_q, cols_q;
	logic [UPL_W-1:0]  upl_q;

	logic [STORE_DEPTH-1:0] vld_q;
	logic                   wb_q;
	logic [BANK_W-1:0]      widx_q;
	logic [DIM_W-1:0]       mod_q, div_q;
	logic [LIVE_W-1:0]      live_q;
	logic [GEOM_W-1:0]      units_q;
	logic [7:0]             mask_q;
	logic [PT_W-1:0]        src_q;

	logic [DATA_W-1:0] mem [STORE_DEPTH];
	logic [DATA_W-1:0] rd_s1;
	logic              v_s1;
	result_t           res_s1;

	logic              out_v_q;
	result_t           out_res_q;
	logic [DATA_W-1:0] out_data_q;

	logic              acc, mv;
	logic              present;
	logic [PT_W-1:0]   pt;
	logic              flush;
	logic              wb_e;
	logic [BANK_W-1:0] widx_e;
	logic [DIM_W-1:0]  mod_e, div_e;
	logic [LIVE_W-1:0] live_e;
	logic [GEOM_W-1:0] units_e;
	logic [7:0]        mask_e;
	logic [STORE_DEPTH-1:0] vld_e, vld_n;
	logic [PT_W-1:0]   src_n;
	logic              was_empty;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [ADDR_W-1:0] rpos;
	logic [ADDR_W-1:0] size;
	logic              got;
	logic [LIVE_W-1:0] live_n;
	logic [ADDR_W-1:0] widx_inc;
	logic [DIM_W:0]    mod_inc;
	logic              wb_n;
	logic [BANK_W-1:0] widx_n;
	logic [DIM_W-1:0]  mod_n, div_n;
	logic [7:0]        mask_sh, mask_n;
	logic [GEOM_W-1:0] units_inc, units_n;
	logic              close, ready;
	logic [GEOM_W-1:0] rows_m1, cols_m1;
	logic [DIM_W-1:0]  phase;
	result_t           res_n;
	logic              geom_ok;

	assign present = s_axis_tuser[0];
	assign pt      = s_axis_tuser[7:1];

	assign mv  = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || mv;
	assign acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		flush   = present && (units_q != '0) && (pt != src_q);
		wb_e    = flush ? 1'b0 : wb_q;
		widx_e  = flush ? '0 : widx_q;
		mod_e   = flush ? '0 : mod_q;
		div_e   = flush ? '0 : div_q;
		live_e  = flush ? '0 : live_q;
		units_e = flush ? '0 : units_q;
		mask_e  = flush ? '0 : mask_q;
		vld_e   = flush ? '0 : vld_q;

		src_n     = (present && (units_e == '0)) ? pt : src_q;
		was_empty = (live_e == '0);

		size  = ADDR_W'({3'b0, rows_q} * {3'b0, cols_q});
		rpos  = ADDR_W'({4'b0, mod_e} * {3'b0, cols_q}) + ADDR_W'(div_e);
		waddr = {wb_e, widx_e};
		raddr = {~wb_e, rpos[BANK_W-1:0]};

		got          = vld_e[raddr];
		vld_n        = vld_e;
		vld_n[waddr] = present;
		vld_n[raddr] = 1'b0;
		live_n = live_e + LIVE_W'(present) - LIVE_W'(got);

		widx_inc = {1'b0, widx_e} + ADDR_W'(1);
		mod_inc  = {1'b0, mod_e} + (DIM_W+1)'(1);
		if (mod_inc >= rows_q) begin
			mod_n = '0;
			div_n = div_e + DIM_W'(1);
		end else begin
			mod_n = mod_inc[DIM_W-1:0];
			div_n = div_e;
		end
		wb_n   = wb_e;
		widx_n = widx_inc[BANK_W-1:0];
		if (widx_inc >= size) begin
			widx_n = '0;
			mod_n  = '0;
			div_n  = '0;
			wb_n   = ~wb_e;
		end

		mask_sh   = {mask_e[6:0], got};
		units_inc = units_e + GEOM_W'(1);
		close     = (units_inc >= rows_q);
		ready     = close && (mask_sh != '0);
		units_n   = close ? '0 : units_inc;
		mask_n    = ready ? '0 : mask_sh;

		rows_m1 = rows_q - GEOM_W'(1);
		cols_m1 = cols_q - GEOM_W'(1);
		phase   = (div_n == '0) ? cols_m1[DIM_W-1:0] : div_n - DIM_W'(1);

		res_n.present       = got;
		res_n.packet_ready  = ready;
		res_n.new_timestamp = ready && was_empty;
		res_n.header_word   = ready ? {src_n, upl_q, rows_m1[2:0], cols_m1[2:0],
			phase, mask_sh} : '0;

		geom_ok = (cfg_data >= CFG_W'(1)) && (cfg_data <= CFG_W'(MAX_DIM));
	end

	// store data, no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			mem[waddr] <= s_axis_tdata;
			rd_s1      <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RESET;
			cols_q  <= COLUMNS_RESET;
			upl_q   <= UPL_RESET;
			vld_q   <= '0;
			wb_q    <= 1'b0;
			widx_q  <= '0;
			mod_q   <= '0;
			div_q   <= '0;
			live_q  <= '0;
			units_q <= '0;
			mask_q  <= '0;
			src_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS, REG_COLUMNS: begin
					if (geom_ok) begin
						if (cfg_index == REG_ROWS) begin
							rows_q <= cfg_data[GEOM_W-1:0];
						end else begin
							cols_q <= cfg_data[GEOM_W-1:0];
						end
						vld_q   <= '0;
						wb_q    <= 1'b0;
						widx_q  <= '0;
						mod_q   <= '0;
						div_q   <= '0;
						live_q  <= '0;
						units_q <= '0;
						mask_q  <= '0;
					end
				end
				REG_UPL: begin
					upl_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			vld_q   <= vld_n;
			wb_q    <= wb_n;
			widx_q  <= widx_n;
			mod_q   <= mod_n;
			div_q   <= div_n;
			live_q  <= live_n;
			units_q <= units_n;
			mask_q  <= mask_n;
			src_q   <= src_n;
		end
	end

	// result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (mv) begin
				v_s1 <= 1'b0;
			end
			if (mv) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_n;
		end
		if (mv) begin
			out_res_q  <= res_s1;
			out_data_q <= res_s1.present ? rd_s1 : '0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_res_q.header_word, out_data_q};
	assign m_axis_tuser  = {out_res_q.new_timestamp, out_res_q.present};
	assign m_axis_tlast  = out_res_q.packet_ready;

endmodule
